/* rtl/cubemap_bilinear_texture_sampler_core_defines.svh */
`ifndef CUBEMAP_BILINEAR_TEXTURE_SAMPLER_CORE_DEFINES_SVH
`define CUBEMAP_BILINEAR_TEXTURE_SAMPLER_CORE_DEFINES_SVH

// Same-cycle implication, checked on i_clk, off during reset.
`define CBS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication after a fixed number of cycles.
`define CBS_ASSERT_DLY(label, ante, dly, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> ##dly (cons)) else $error(msg);

`endif

/* rtl/cbs_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package cbs_pkg;

    // uv fixed point: C_UV_FRAC fraction bits, one extra bit holds 1.0
    localparam int C_UV_FRAC = 16;
    localparam int C_UV_W    = C_UV_FRAC + 1;
    localparam logic [C_UV_W-1:0] C_UV_ONE  = C_UV_W'(2 ** C_UV_FRAC);
    localparam logic [C_UV_W-1:0] C_UV_HALF = C_UV_W'(2 ** (C_UV_FRAC - 1));
    localparam int C_RND = 2 ** (C_UV_FRAC - 1);

    // divider: quotient bits resolved per pipeline stage
    localparam int C_DIV_STEPS  = 4;
    localparam int C_DIV_STAGES = (C_UV_W + C_DIV_STEPS - 1) / C_DIV_STEPS;

    // strip v: (p + face * one) / 6 via reciprocal multiply
    localparam int C_VN_W     = C_UV_FRAC + 3;
    localparam int C_RECIP_SH = C_VN_W + 3;
    localparam int C_RECIP_W  = C_RECIP_SH - 2;
    localparam logic [C_RECIP_W-1:0] C_RECIP_6 = C_RECIP_W'((2 ** C_RECIP_SH + 5) / 6);

    // texture dimensions and address math
    localparam int C_DIM_W   = 14;
    localparam int C_COORD_W = C_DIM_W + 1;
    localparam int C_POS_W   = C_UV_W + C_DIM_W;
    localparam int C_LIN_W   = 2 * C_DIM_W + 1;
    localparam logic [C_DIM_W-1:0] C_WIDTH_RESET  = C_DIM_W'(32);
    localparam logic [C_DIM_W-1:0] C_HEIGHT_RESET = C_DIM_W'(192);

    localparam int C_TEXEL_COUNT  = 8192;
    localparam int C_CHANNEL_BITS = 16;

    // face, divider, address, memory, blend
    localparam int C_LATENCY = 1 + C_DIV_STAGES + 4 + 1 + 4;

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SAMPLE = 1'b1
    } t_opcode;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    typedef enum logic {
        CFG_TEX_WIDTH  = 1'b0,
        CFG_TEX_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        t_opcode            opcode;
        logic [12:0]        texel_index;
        logic [15:0]        texel_red;
        logic [15:0]        texel_green;
        logic [15:0]        texel_blue;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
    } t_cmd;

    typedef struct packed {
        logic [15:0] sample_red;
        logic [15:0] sample_green;
        logic [15:0] sample_blue;
    } t_sample;

    // travels alongside the divider
    typedef struct packed {
        t_opcode     opcode;
        t_face       face;
        logic        zero;
        logic [12:0] texel_index;
        logic [15:0] texel_red;
        logic [15:0] texel_green;
        logic [15:0] texel_blue;
    } t_side;

    // addressing stage to memory stage
    typedef struct packed {
        t_opcode              opcode;
        logic [12:0]          texel_index;
        logic [15:0]          texel_red;
        logic [15:0]          texel_green;
        logic [15:0]          texel_blue;
        logic [C_UV_FRAC-1:0] du;
        logic [C_UV_FRAC-1:0] dv;
    } t_fetch;

endpackage

`default_nettype wire

/* rtl/cbs_div.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "cubemap_bilinear_texture_sampler_core_defines.svh"

module cbs_div
    import cbs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic [C_UV_W-1:0] i_num_a,
    input  wire logic [C_UV_W-1:0] i_num_b,
    input  wire logic [C_UV_W-1:0] i_den,
    input  wire t_side             i_side,
    output logic                   o_valid,
    output logic [C_UV_W-1:0]      o_quo_a,
    output logic [C_UV_W-1:0]      o_quo_b,
    output t_side                  o_side
);

    // restoring division, num <= den so the quotient fits C_UV_W bits;
    // first step has no shift (integer bit), the rest produce fraction bits
    function automatic logic [2*C_UV_W-1:0] f_steps(
        input logic [C_UV_W-1:0] rem_in,
        input logic [C_UV_W-1:0] quo_in,
        input logic [C_UV_W-1:0] den,
        input int                base
    );
        logic [C_UV_W-1:0] rem;
        logic [C_UV_W-1:0] quo;
        logic [C_UV_W:0]   sh;
        rem = rem_in;
        quo = quo_in;
        for (int k = 0; k < C_DIV_STEPS; k++) begin
            if (base + k < C_UV_W) begin
                sh = (base + k == 0) ? {1'b0, rem} : {rem, 1'b0};
                if (sh >= {1'b0, den}) begin
                    rem = C_UV_W'(sh - {1'b0, den});
                    quo = {quo[C_UV_W-2:0], 1'b1};
                end else begin
                    rem = sh[C_UV_W-1:0];
                    quo = {quo[C_UV_W-2:0], 1'b0};
                end
            end
        end
        return {quo, rem};
    endfunction

    logic              r_valid [C_DIV_STAGES];
    logic [C_UV_W-1:0] r_rem_a [C_DIV_STAGES];
    logic [C_UV_W-1:0] r_rem_b [C_DIV_STAGES];
    logic [C_UV_W-1:0] r_quo_a [C_DIV_STAGES];
    logic [C_UV_W-1:0] r_quo_b [C_DIV_STAGES];
    logic [C_UV_W-1:0] r_den   [C_DIV_STAGES];
    t_side             r_side  [C_DIV_STAGES];

    for (genvar s = 0; s < C_DIV_STAGES; s++) begin : g_stage
        logic              valid_in;
        logic [C_UV_W-1:0] rem_a_in;
        logic [C_UV_W-1:0] rem_b_in;
        logic [C_UV_W-1:0] quo_a_in;
        logic [C_UV_W-1:0] quo_b_in;
        logic [C_UV_W-1:0] den_in;
        t_side             side_in;
        logic [C_UV_W-1:0] n_rem_a;
        logic [C_UV_W-1:0] n_rem_b;
        logic [C_UV_W-1:0] n_quo_a;
        logic [C_UV_W-1:0] n_quo_b;

        if (s == 0) begin : g_head
            assign valid_in = i_valid;
            assign rem_a_in = i_num_a;
            assign rem_b_in = i_num_b;
            assign quo_a_in = '0;
            assign quo_b_in = '0;
            assign den_in   = i_den;
            assign side_in  = i_side;
        end else begin : g_link
            assign valid_in = r_valid[s-1];
            assign rem_a_in = r_rem_a[s-1];
            assign rem_b_in = r_rem_b[s-1];
            assign quo_a_in = r_quo_a[s-1];
            assign quo_b_in = r_quo_b[s-1];
            assign den_in   = r_den[s-1];
            assign side_in  = r_side[s-1];
        end

        always_comb begin
            {n_quo_a, n_rem_a} = f_steps(rem_a_in, quo_a_in, den_in, s * C_DIV_STEPS);
            {n_quo_b, n_rem_b} = f_steps(rem_b_in, quo_b_in, den_in, s * C_DIV_STEPS);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else begin
                r_valid[s] <= valid_in;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem_a[s] <= n_rem_a;
            r_rem_b[s] <= n_rem_b;
            r_quo_a[s] <= n_quo_a;
            r_quo_b[s] <= n_quo_b;
            r_den[s]   <= den_in;
            r_side[s]  <= side_in;
        end
    end

    assign o_valid = r_valid[C_DIV_STAGES-1];
    assign o_quo_a = r_quo_a[C_DIV_STAGES-1];
    assign o_quo_b = r_quo_b[C_DIV_STAGES-1];
    assign o_side  = r_side[C_DIV_STAGES-1];

    `CBS_ASSERT_IMPL(a_quo_range, o_valid && !o_side.zero, (o_quo_a <= C_UV_ONE) && (o_quo_b <= C_UV_ONE), "face coordinate above 1.0")

endmodule

`default_nettype wire

/* rtl/cbs_addr.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbs_addr
    import cbs_pkg::*;
#(
    parameter int TEXEL_COUNT = C_TEXEL_COUNT,
    localparam int AW = $clog2(TEXEL_COUNT)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    input  wire logic [C_UV_W-1:0]  i_quo_u,
    input  wire logic [C_UV_W-1:0]  i_quo_v,
    input  wire t_side              i_side,
    input  wire logic [C_DIM_W-1:0] i_tex_width,
    input  wire logic [C_DIM_W-1:0] i_tex_height,
    output logic                    o_valid,
    output t_fetch                  o_fetch,
    output logic [AW-1:0]           o_addr00,
    output logic [AW-1:0]           o_addr10,
    output logic [AW-1:0]           o_addr01,
    output logic [AW-1:0]           o_addr11
);

    localparam logic [C_LIN_W-1:0] LP_COUNT = C_LIN_W'(TEXEL_COUNT);
    localparam logic [AW-1:0]      LP_LAST  = AW'(TEXEL_COUNT - 1);

    function automatic logic [AW-1:0] f_clamp(input logic [C_LIN_W-1:0] a);
        return (a >= LP_COUNT) ? LP_LAST : a[AW-1:0];
    endfunction

    logic [C_DIM_W-1:0] w_wd;
    logic [C_DIM_W-1:0] w_hd;

    // zero size reads as one
    assign w_wd = (i_tex_width == '0) ? C_DIM_W'(1) : i_tex_width;
    assign w_hd = (i_tex_height == '0) ? C_DIM_W'(1) : i_tex_height;

    // stage 1: pick uv, strip offset, reciprocal multiply
    logic [C_UV_W-1:0]           n_u;
    logic [C_UV_W-1:0]           n_vf;
    logic [C_VN_W-1:0]           n_vn;
    logic                        r_a1_valid;
    logic [C_UV_W-1:0]           r_a1_u;
    logic [C_VN_W+C_RECIP_W-1:0] r_a1_vprod;
    t_side                       r_a1_side;

    always_comb begin
        n_u  = i_side.zero ? C_UV_HALF : i_quo_u;
        n_vf = i_side.zero ? C_UV_HALF : i_quo_v;
        n_vn = C_VN_W'(n_vf) + (C_VN_W'(i_side.face) << C_UV_FRAC);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1_valid <= 1'b0;
        end else begin
            r_a1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a1_u     <= n_u;
        r_a1_vprod <= (C_VN_W + C_RECIP_W)'(n_vn) * (C_VN_W + C_RECIP_W)'(C_RECIP_6);
        r_a1_side  <= i_side;
    end

    // stage 2: scale to texel space
    logic [C_UV_W-1:0]  n_v;
    logic               r_a2_valid;
    logic [C_POS_W-1:0] r_a2_cpos;
    logic [C_POS_W-1:0] r_a2_rpos;
    t_side              r_a2_side;

    always_comb begin
        n_v = r_a1_vprod[C_RECIP_SH +: C_UV_W];
        if (n_v > C_UV_ONE) begin
            n_v = C_UV_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a2_valid <= 1'b0;
        end else begin
            r_a2_valid <= r_a1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a2_cpos <= C_POS_W'(r_a1_u) * C_POS_W'(w_wd - C_DIM_W'(1));
        r_a2_rpos <= C_POS_W'(n_v) * C_POS_W'(w_hd - C_DIM_W'(1));
        r_a2_side <= r_a1_side;
    end

    // stage 3: split into neighbors and fractions, row base
    logic [C_COORD_W-1:0] n_c0;
    logic [C_COORD_W-1:0] n_r0;
    logic [C_UV_FRAC-1:0] n_du;
    logic [C_UV_FRAC-1:0] n_dv;
    logic                 r_a3_valid;
    logic [C_LIN_W-1:0]   r_a3_r0w;
    logic [C_COORD_W-1:0] r_a3_c0;
    logic [C_COORD_W-1:0] r_a3_c1;
    logic [C_UV_FRAC-1:0] r_a3_du;
    logic [C_UV_FRAC-1:0] r_a3_dv;
    t_side                r_a3_side;

    always_comb begin
        n_c0 = r_a2_cpos[C_POS_W-1:C_UV_FRAC];
        n_r0 = r_a2_rpos[C_POS_W-1:C_UV_FRAC];
        n_du = r_a2_cpos[C_UV_FRAC-1:0];
        n_dv = r_a2_rpos[C_UV_FRAC-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a3_valid <= 1'b0;
        end else begin
            r_a3_valid <= r_a2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a3_r0w  <= C_LIN_W'(n_r0) * C_LIN_W'(w_wd);
        r_a3_c0   <= n_c0;
        r_a3_c1   <= n_c0 + C_COORD_W'(n_du != '0);
        r_a3_du   <= n_du;
        r_a3_dv   <= n_dv;
        r_a3_side <= r_a2_side;
    end

    // stage 4: four linear addresses, clamped
    logic [C_LIN_W-1:0] n_r1w;
    logic               r_valid;
    t_fetch             r_fetch;
    logic [AW-1:0]      r_addr00;
    logic [AW-1:0]      r_addr10;
    logic [AW-1:0]      r_addr01;
    logic [AW-1:0]      r_addr11;

    assign n_r1w = r_a3_r0w + ((r_a3_dv != '0) ? C_LIN_W'(w_wd) : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_a3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr00            <= f_clamp(r_a3_r0w + C_LIN_W'(r_a3_c0));
        r_addr10            <= f_clamp(r_a3_r0w + C_LIN_W'(r_a3_c1));
        r_addr01            <= f_clamp(n_r1w + C_LIN_W'(r_a3_c0));
        r_addr11            <= f_clamp(n_r1w + C_LIN_W'(r_a3_c1));
        r_fetch.opcode      <= r_a3_side.opcode;
        r_fetch.texel_index <= r_a3_side.texel_index;
        r_fetch.texel_red   <= r_a3_side.texel_red;
        r_fetch.texel_green <= r_a3_side.texel_green;
        r_fetch.texel_blue  <= r_a3_side.texel_blue;
        r_fetch.du          <= r_a3_du;
        r_fetch.dv          <= r_a3_dv;
    end

    assign o_valid  = r_valid;
    assign o_fetch  = r_fetch;
    assign o_addr00 = r_addr00;
    assign o_addr10 = r_addr10;
    assign o_addr01 = r_addr01;
    assign o_addr11 = r_addr11;

endmodule

`default_nettype wire

/* rtl/cbs_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbs_mem
    import cbs_pkg::*;
#(
    parameter int TEXEL_COUNT  = C_TEXEL_COUNT,
    parameter int CHANNEL_BITS = C_CHANNEL_BITS,
    localparam int AW = $clog2(TEXEL_COUNT),
    localparam int TW = 3 * CHANNEL_BITS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire t_fetch        i_fetch,
    input  wire logic [AW-1:0] i_addr00,
    input  wire logic [AW-1:0] i_addr10,
    input  wire logic [AW-1:0] i_addr01,
    input  wire logic [AW-1:0] i_addr11,
    output logic               o_valid,
    output logic [TW-1:0]      o_tex00,
    output logic [TW-1:0]      o_tex10,
    output logic [TW-1:0]      o_tex01,
    output logic [TW-1:0]      o_tex11,
    output logic [C_UV_FRAC-1:0] o_du,
    output logic [C_UV_FRAC-1:0] o_dv
);

    // two copies, each written alike and read at two addresses:
    // copy a serves the upper row pair, copy b the lower
    logic [TW-1:0] r_mem_a [TEXEL_COUNT];
    logic [TW-1:0] r_mem_b [TEXEL_COUNT];

    logic          w_we;
    logic          w_rd;
    logic [AW-1:0] w_waddr;
    logic [TW-1:0] w_wdata;

    assign w_we    = i_valid && (i_fetch.opcode == OP_WRITE)
                     && (32'(i_fetch.texel_index) < 32'(TEXEL_COUNT));
    assign w_rd    = i_valid && (i_fetch.opcode == OP_SAMPLE);
    assign w_waddr = AW'(i_fetch.texel_index);
    assign w_wdata = {CHANNEL_BITS'(i_fetch.texel_blue), CHANNEL_BITS'(i_fetch.texel_green),
                      CHANNEL_BITS'(i_fetch.texel_red)};

    logic [TW-1:0]        r_tex00;
    logic [TW-1:0]        r_tex10;
    logic [TW-1:0]        r_tex01;
    logic [TW-1:0]        r_tex11;
    logic                 r_valid;
    logic [C_UV_FRAC-1:0] r_du;
    logic [C_UV_FRAC-1:0] r_dv;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_a[w_waddr] <= w_wdata;
        end
        if (w_rd) begin
            r_tex00 <= r_mem_a[i_addr00];
            r_tex10 <= r_mem_a[i_addr10];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem_b[w_waddr] <= w_wdata;
        end
        if (w_rd) begin
            r_tex01 <= r_mem_b[i_addr01];
            r_tex11 <= r_mem_b[i_addr11];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= w_rd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_du <= i_fetch.du;
        r_dv <= i_fetch.dv;
    end

    assign o_valid = r_valid;
    assign o_tex00 = r_tex00;
    assign o_tex10 = r_tex10;
    assign o_tex01 = r_tex01;
    assign o_tex11 = r_tex11;
    assign o_du    = r_du;
    assign o_dv    = r_dv;

endmodule

`default_nettype wire

/* rtl/cbs_blend.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbs_blend
    import cbs_pkg::*;
#(
    parameter int CHANNEL_BITS = C_CHANNEL_BITS,
    localparam int TW = 3 * CHANNEL_BITS
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [TW-1:0]        i_tex00,
    input  wire logic [TW-1:0]        i_tex10,
    input  wire logic [TW-1:0]        i_tex01,
    input  wire logic [TW-1:0]        i_tex11,
    input  wire logic [C_UV_FRAC-1:0] i_du,
    input  wire logic [C_UV_FRAC-1:0] i_dv,
    output logic                      o_valid,
    output t_sample                   o_sample
);

    localparam int CB = CHANNEL_BITS;
    localparam int PW = CB + C_UV_FRAC + 2;

    // lerp(a, b, t) = a + round((b - a) * t / 2^F), one multiply per lerp
    logic                        r_b1_valid;
    logic                        r_b2_valid;
    logic                        r_b3_valid;
    logic                        r_b4_valid;
    logic [C_UV_FRAC-1:0]        r_b1_dv;
    logic [C_UV_FRAC-1:0]        r_b2_dv;
    logic signed [PW-1:0]        r_b1_pt  [3];
    logic signed [PW-1:0]        r_b1_pb  [3];
    logic [CB-1:0]               r_b1_at  [3];
    logic [CB-1:0]               r_b1_ab  [3];
    logic [CB-1:0]               r_b2_top [3];
    logic [CB-1:0]               r_b2_bot [3];
    logic signed [PW-1:0]        r_b3_p   [3];
    logic [CB-1:0]               r_b3_top [3];
    logic [15:0]                 r_b4_res [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_b2_valid <= 1'b0;
            r_b3_valid <= 1'b0;
            r_b4_valid <= 1'b0;
        end else begin
            r_b1_valid <= i_valid;
            r_b2_valid <= r_b1_valid;
            r_b3_valid <= r_b2_valid;
            r_b4_valid <= r_b3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b1_dv <= i_dv;
        r_b2_dv <= r_b1_dv;
    end

    for (genvar c = 0; c < 3; c++) begin : g_chan
        logic [CB-1:0]        a00;
        logic [CB-1:0]        a10;
        logic [CB-1:0]        a01;
        logic [CB-1:0]        a11;
        logic signed [CB:0]   d_top;
        logic signed [CB:0]   d_bot;
        logic signed [CB:0]   d_col;
        logic signed [PW-1:0] s_top;
        logic signed [PW-1:0] s_bot;
        logic signed [PW-1:0] s_col;

        always_comb begin
            a00   = i_tex00[c*CB +: CB];
            a10   = i_tex10[c*CB +: CB];
            a01   = i_tex01[c*CB +: CB];
            a11   = i_tex11[c*CB +: CB];
            d_top = signed'({1'b0, a10}) - signed'({1'b0, a00});
            d_bot = signed'({1'b0, a11}) - signed'({1'b0, a01});
            d_col = signed'({1'b0, r_b2_bot[c]}) - signed'({1'b0, r_b2_top[c]});
            s_top = (r_b1_pt[c] + PW'(C_RND)) >>> C_UV_FRAC;
            s_bot = (r_b1_pb[c] + PW'(C_RND)) >>> C_UV_FRAC;
            s_col = (r_b3_p[c] + PW'(C_RND)) >>> C_UV_FRAC;
        end

        always_ff @(posedge i_clk) begin
            r_b1_pt[c]  <= PW'(d_top) * PW'(signed'({1'b0, i_du}));
            r_b1_pb[c]  <= PW'(d_bot) * PW'(signed'({1'b0, i_du}));
            r_b1_at[c]  <= a00;
            r_b1_ab[c]  <= a01;
            r_b2_top[c] <= r_b1_at[c] + CB'(s_top);
            r_b2_bot[c] <= r_b1_ab[c] + CB'(s_bot);
            r_b3_p[c]   <= PW'(d_col) * PW'(signed'({1'b0, r_b2_dv}));
            r_b3_top[c] <= r_b2_top[c];
            r_b4_res[c] <= 16'(CB'(r_b3_top[c] + CB'(s_col)));
        end
    end

    assign o_valid               = r_b4_valid;
    assign o_sample.sample_red   = r_b4_res[0];
    assign o_sample.sample_green = r_b4_res[1];
    assign o_sample.sample_blue  = r_b4_res[2];

endmodule

`default_nettype wire

/* rtl/cubemap_bilinear_texture_sampler_core.sv */
// Cube-map texture unit with bilinear filtering. A command word is taken on
// every clock where start is high (busy never rises): a write stores one RGB
// texel, a sample returns one blended RGB word on o_sample, flagged by o_valid
// for a single cycle. Commands stream at one per clock; the pipeline runs
// through face select, the five-stage face coordinate divider, address math,
// texel read and two lerp passes. There is no backpressure, so the receiver
// must capture every o_valid word. Writes and samples stay in order, so a
// sample sees every earlier write. The texel store has no reset; sampling
// texels never written returns garbage. Change tex_width and tex_height only
// with no commands in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "cubemap_bilinear_texture_sampler_core_defines.svh"

module cubemap_bilinear_texture_sampler_core
    import cbs_pkg::*;
#(
    parameter int TEXEL_COUNT  = C_TEXEL_COUNT,
    parameter int CHANNEL_BITS = C_CHANNEL_BITS
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire t_cmd               i_cmd,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [C_DIM_W-1:0] i_cfg_data,
    output logic                    o_valid,
    output t_sample                 o_sample
);

    localparam int AW = $clog2(TEXEL_COUNT);
    localparam int TW = 3 * CHANNEL_BITS;

    function automatic logic [C_UV_W-1:0] f_abs(input logic signed [15:0] v);
        logic signed [C_UV_W-1:0] e;
        e = C_UV_W'(v);
        return v[15] ? C_UV_W'(-e) : C_UV_W'(e);
    endfunction

    assign busy = 1'b0;

    // config registers
    logic [C_DIM_W-1:0] r_tex_width;
    logic [C_DIM_W-1:0] r_tex_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= C_WIDTH_RESET;
            r_tex_height <= C_HEIGHT_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_TEX_WIDTH:  r_tex_width  <= i_cfg_data;
                CFG_TEX_HEIGHT: r_tex_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // face select: largest magnitude, ties Z over Y over X
    logic                     w_accept;
    logic [C_UV_W-1:0]        n_ax;
    logic [C_UV_W-1:0]        n_ay;
    logic [C_UV_W-1:0]        n_az;
    logic signed [C_UV_W-1:0] n_xs;
    logic signed [C_UV_W-1:0] n_ys;
    logic signed [C_UV_W-1:0] n_zs;
    logic signed [C_UV_W-1:0] n_fu;
    logic signed [C_UV_W-1:0] n_fv;
    logic [C_UV_W-1:0]        n_m;
    t_face                    n_face;
    logic signed [C_UV_W:0]   n_su;
    logic signed [C_UV_W:0]   n_sv;
    t_side                    n_side;

    assign w_accept = start && !busy;

    always_comb begin
        n_ax = f_abs(i_cmd.dir_x);
        n_ay = f_abs(i_cmd.dir_y);
        n_az = f_abs(i_cmd.dir_z);
        n_xs = C_UV_W'(i_cmd.dir_x);
        n_ys = C_UV_W'(i_cmd.dir_y);
        n_zs = C_UV_W'(i_cmd.dir_z);
        if (n_az >= n_ax && n_az >= n_ay) begin
            n_face = i_cmd.dir_z[15] ? FACE_NEG_Z : FACE_POS_Z;
            n_fu   = i_cmd.dir_z[15] ? -n_xs : n_xs;
            n_fv   = n_ys;
            n_m    = n_az;
        end else if (n_ay >= n_ax) begin
            n_face = i_cmd.dir_y[15] ? FACE_NEG_Y : FACE_POS_Y;
            n_fu   = n_xs;
            n_fv   = i_cmd.dir_y[15] ? n_zs : -n_zs;
            n_m    = n_ay;
        end else begin
            n_face = i_cmd.dir_x[15] ? FACE_NEG_X : FACE_POS_X;
            n_fu   = i_cmd.dir_x[15] ? n_zs : -n_zs;
            n_fv   = n_ys;
            n_m    = n_ax;
        end
        // |f| <= m, so f + m lies in 0..2m
        n_su = (C_UV_W + 1)'(n_fu) + signed'({1'b0, n_m});
        n_sv = (C_UV_W + 1)'(n_fv) + signed'({1'b0, n_m});
        n_side.opcode      = i_cmd.opcode;
        n_side.face        = n_face;
        n_side.zero        = (n_m == '0);
        n_side.texel_index = i_cmd.texel_index;
        n_side.texel_red   = i_cmd.texel_red;
        n_side.texel_green = i_cmd.texel_green;
        n_side.texel_blue  = i_cmd.texel_blue;
    end

    logic              r_f_valid;
    logic [C_UV_W-1:0] r_f_num_u;
    logic [C_UV_W-1:0] r_f_num_v;
    logic [C_UV_W-1:0] r_f_den;
    t_side             r_f_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_valid <= 1'b0;
        end else begin
            r_f_valid <= w_accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f_num_u <= n_su[C_UV_W-1:0];
        r_f_num_v <= n_sv[C_UV_W-1:0];
        r_f_den   <= C_UV_W'({n_m, 1'b0});
        r_f_side  <= n_side;
    end

    logic              w_d_valid;
    logic [C_UV_W-1:0] w_quo_u;
    logic [C_UV_W-1:0] w_quo_v;
    t_side             w_d_side;

    cbs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_f_valid),
        .i_num_a (r_f_num_u),
        .i_num_b (r_f_num_v),
        .i_den   (r_f_den),
        .i_side  (r_f_side),
        .o_valid (w_d_valid),
        .o_quo_a (w_quo_u),
        .o_quo_b (w_quo_v),
        .o_side  (w_d_side)
    );

    logic          w_a_valid;
    t_fetch        w_a_fetch;
    logic [AW-1:0] w_addr00;
    logic [AW-1:0] w_addr10;
    logic [AW-1:0] w_addr01;
    logic [AW-1:0] w_addr11;

    cbs_addr #(
        .TEXEL_COUNT (TEXEL_COUNT)
    ) u_addr (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_d_valid),
        .i_quo_u      (w_quo_u),
        .i_quo_v      (w_quo_v),
        .i_side       (w_d_side),
        .i_tex_width  (r_tex_width),
        .i_tex_height (r_tex_height),
        .o_valid      (w_a_valid),
        .o_fetch      (w_a_fetch),
        .o_addr00     (w_addr00),
        .o_addr10     (w_addr10),
        .o_addr01     (w_addr01),
        .o_addr11     (w_addr11)
    );

    logic                 w_m_valid;
    logic [TW-1:0]        w_tex00;
    logic [TW-1:0]        w_tex10;
    logic [TW-1:0]        w_tex01;
    logic [TW-1:0]        w_tex11;
    logic [C_UV_FRAC-1:0] w_du;
    logic [C_UV_FRAC-1:0] w_dv;

    cbs_mem #(
        .TEXEL_COUNT  (TEXEL_COUNT),
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_mem (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_a_valid),
        .i_fetch  (w_a_fetch),
        .i_addr00 (w_addr00),
        .i_addr10 (w_addr10),
        .i_addr01 (w_addr01),
        .i_addr11 (w_addr11),
        .o_valid  (w_m_valid),
        .o_tex00  (w_tex00),
        .o_tex10  (w_tex10),
        .o_tex01  (w_tex01),
        .o_tex11  (w_tex11),
        .o_du     (w_du),
        .o_dv     (w_dv)
    );

    cbs_blend #(
        .CHANNEL_BITS (CHANNEL_BITS)
    ) u_blend (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_m_valid),
        .i_tex00  (w_tex00),
        .i_tex10  (w_tex10),
        .i_tex01  (w_tex01),
        .i_tex11  (w_tex11),
        .i_du     (w_du),
        .i_dv     (w_dv),
        .o_valid  (o_valid),
        .o_sample (o_sample)
    );

    `CBS_ASSERT_DLY(a_write_silent, start && i_cmd.opcode == OP_WRITE, C_LATENCY, !o_valid, "write produced a sample word")
    `CBS_ASSERT_DLY(a_sample_word, start && i_cmd.opcode == OP_SAMPLE, C_LATENCY, o_valid, "sample word missing")

endmodule

`default_nettype wire

/* tb/cbs_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module cbs_checker
    import cbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire t_cmd               i_cmd,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_idx,
    input  wire logic [C_DIM_W-1:0] i_cfg_data,
    input  wire logic               o_valid,
    input  wire t_sample            o_sample,
    output int                      fail_count,
    output int                      pending_count
);

    localparam longint UV1 = 64'd1 << C_UV_FRAC;

    t_sample             texels [C_TEXEL_COUNT];
    t_sample             expected_words [$];
    logic [C_DIM_W-1:0]  tex_w;
    logic [C_DIM_W-1:0]  tex_h;

    function automatic longint face_pos(longint f, longint m);
        longint p;
        p = ((f + m) << C_UV_FRAC) / (2 * m);
        return (p > UV1) ? UV1 : p;
    endfunction

    function automatic longint lerp(longint a, longint b, longint t);
        return (a * (UV1 - t) + b * t + (UV1 >> 1)) >> C_UV_FRAC;
    endfunction

    function automatic longint texel_addr(longint row, longint col, longint w);
        longint a;
        a = row * w + col;
        return (a >= C_TEXEL_COUNT) ? C_TEXEL_COUNT - 1 : a;
    endfunction

    function automatic t_sample predict_sample(t_cmd c);
        longint x, y, z, ax, ay, az, m, fu, fv, u, v, w, h;
        longint cpos, rpos, c0, c1, r0, r1, du, dv;
        longint a00, a10, a01, a11;
        t_face   face;
        t_sample s00, s10, s01, s11, res;
        x = longint'(c.dir_x);
        y = longint'(c.dir_y);
        z = longint'(c.dir_z);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;
        // ties: Z over Y over X
        if (az >= ax && az >= ay) begin
            face = (z >= 0) ? FACE_POS_Z : FACE_NEG_Z;
            fu = (z >= 0) ? x : -x;
            fv = y;
            m = az;
        end else if (ay >= ax) begin
            face = (y >= 0) ? FACE_POS_Y : FACE_NEG_Y;
            fu = x;
            fv = (y >= 0) ? -z : z;
            m = ay;
        end else begin
            face = (x >= 0) ? FACE_POS_X : FACE_NEG_X;
            fu = (x >= 0) ? -z : z;
            fv = y;
            m = ax;
        end
        if (m == 0) begin
            u = UV1 >> 1;
            v = UV1 >> 1;
        end else begin
            u = face_pos(fu, m);
            v = face_pos(fv, m);
        end
        v = (v + longint'(face) * UV1) / 6;
        if (v > UV1) v = UV1;
        w = (tex_w == 0) ? 1 : longint'(tex_w);
        h = (tex_h == 0) ? 1 : longint'(tex_h);
        cpos = u * (w - 1);
        rpos = v * (h - 1);
        c0 = cpos >> C_UV_FRAC;
        du = cpos & (UV1 - 1);
        c1 = c0 + ((du != 0) ? 1 : 0);
        r0 = rpos >> C_UV_FRAC;
        dv = rpos & (UV1 - 1);
        r1 = r0 + ((dv != 0) ? 1 : 0);
        a00 = texel_addr(r0, c0, w);
        a10 = texel_addr(r0, c1, w);
        a01 = texel_addr(r1, c0, w);
        a11 = texel_addr(r1, c1, w);
        s00 = texels[a00];
        s10 = texels[a10];
        s01 = texels[a01];
        s11 = texels[a11];
        res.sample_red   = 16'(lerp(lerp(s00.sample_red, s10.sample_red, du),
                                    lerp(s01.sample_red, s11.sample_red, du), dv));
        res.sample_green = 16'(lerp(lerp(s00.sample_green, s10.sample_green, du),
                                    lerp(s01.sample_green, s11.sample_green, du), dv));
        res.sample_blue  = 16'(lerp(lerp(s00.sample_blue, s10.sample_blue, du),
                                    lerp(s01.sample_blue, s11.sample_blue, du), dv));
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] exp_v, logic [15:0] got_v);
        $display("[%0t] mismatch %s: expected %h got %h", $time, what, exp_v, got_v);
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        pending_count = 0;
    end

    always @(posedge i_clk) begin
        t_sample exp_s;
        if (!i_rst_n) begin
            expected_words.delete();
            tex_w <= C_WIDTH_RESET;
            tex_h <= C_HEIGHT_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_TEX_WIDTH) tex_w <= i_cfg_data;
                else tex_h <= i_cfg_data;
            end
            // result check first: a sample taken this edge cannot come out now
            if (o_valid) begin
                if (expected_words.size() == 0) begin
                    $display("[%0t] unexpected sample word %h", $time, o_sample);
                    fail_count++;
                end else begin
                    exp_s = expected_words.pop_front();
                    if (o_sample.sample_red != exp_s.sample_red)
                        report_mismatch("red", exp_s.sample_red, o_sample.sample_red);
                    if (o_sample.sample_green != exp_s.sample_green)
                        report_mismatch("green", exp_s.sample_green, o_sample.sample_green);
                    if (o_sample.sample_blue != exp_s.sample_blue)
                        report_mismatch("blue", exp_s.sample_blue, o_sample.sample_blue);
                end
            end
            if (start && !busy) begin
                if (i_cmd.opcode == OP_WRITE) begin
                    texels[i_cmd.texel_index] = '{i_cmd.texel_red, i_cmd.texel_green,
                                                  i_cmd.texel_blue};
                end else begin
                    expected_words.push_back(predict_sample(i_cmd));
                end
            end
        end
        pending_count = expected_words.size();
    end

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
    import cbs_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int LOADED      = 256;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    t_cmd               i_cmd = '0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = 1'b0;
    logic [C_DIM_W-1:0] i_cfg_data = '0;
    logic               o_valid;
    t_sample            o_sample;
    int                 fail_count;
    int                 pending_count;
    int                 idle_pct = 0;
    int                 stall_cycles = 0;

    always #10 i_clk = ~i_clk;

    cubemap_bilinear_texture_sampler_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_sample(o_sample)
    );

    cbs_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_cmd(i_cmd),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .o_sample(o_sample), .fail_count(fail_count),
        .pending_count(pending_count)
    );

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // one word per call; each cycle before it idles at idle_pct percent
    task automatic issue(t_cmd c);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= c;
        forever begin
            @(negedge i_clk);
            if (!busy) begin
                @(posedge i_clk);
                break;
            end
            @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (C_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic set_dims(logic [C_DIM_W-1:0] w, logic [C_DIM_W-1:0] h);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_TEX_WIDTH;
        i_cfg_data <= w;
        @(posedge i_clk);
        i_cfg_idx <= CFG_TEX_HEIGHT;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_cmd write_word(int idx, logic [15:0] r, logic [15:0] g,
                                        logic [15:0] b);
        t_cmd c;
        c = t_cmd'($bits(t_cmd)'({$urandom, $urandom, $urandom, $urandom}));
        c.opcode = OP_WRITE;
        c.texel_index = 13'(idx);
        c.texel_red = r;
        c.texel_green = g;
        c.texel_blue = b;
        return c;
    endfunction

    function automatic t_cmd sample_word(int x, int y, int z);
        t_cmd c;
        c = t_cmd'($bits(t_cmd)'({$urandom, $urandom, $urandom, $urandom}));
        c.opcode = OP_SAMPLE;
        c.dir_x = 16'(x);
        c.dir_y = 16'(y);
        c.dir_z = 16'(z);
        return c;
    endfunction

    function automatic int rand_comp();
        int mag;
        case ($urandom_range(3))
            0: return int'($signed(16'($urandom)));
            1: return $urandom_range(0, 30) - 15;
            2: return $urandom_range(1) ? 32767 : -32768;
            default: begin
                mag = $urandom_range(0, 40000);
                return mag - 20000;
            end
        endcase
    endfunction

    function automatic t_cmd rand_word();
        int x, y, z;
        if ($urandom_range(99) < 25)
            return write_word($urandom_range(C_TEXEL_COUNT - 1), 16'($urandom),
                              16'($urandom), 16'($urandom));
        x = rand_comp();
        y = rand_comp();
        z = rand_comp();
        // magnitude ties exercise the face priority
        case ($urandom_range(5))
            0: y = $urandom_range(1) ? x : -x;
            1: z = $urandom_range(1) ? y : -y;
            2: begin
                y = x;
                z = $urandom_range(1) ? x : -x;
            end
            default: ;
        endcase
        if (x == -32768 && $urandom_range(1)) x = 0;
        return sample_word(x, y, z);
    endfunction

    // for very wide textures: off the +X face every row lands past the end
    // and clamps to the last texel
    function automatic t_cmd wide_word();
        t_cmd c;
        int   ax, ay, az;
        c = rand_word();
        ax = (c.dir_x < 0) ? -int'(c.dir_x) : int'(c.dir_x);
        ay = (c.dir_y < 0) ? -int'(c.dir_y) : int'(c.dir_y);
        az = (c.dir_z < 0) ? -int'(c.dir_z) : int'(c.dir_z);
        if (c.opcode == OP_SAMPLE && ax > ay && ax > az && c.dir_x >= 0)
            c.dir_x = -c.dir_x;
        return c;
    endfunction

    initial begin
        logic [C_DIM_W-1:0] dims [7][2];
        int n;
        dims = '{'{14'd16, 14'd12}, '{14'd1, 14'd1}, '{14'd0, 14'd0},
                 '{14'd16383, 14'd16383}, '{14'd8192, 14'd8192}, '{14'd2, 14'd6},
                 '{14'd9, 14'd28}};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_dims(14'd16, 14'd12);

        // small textures only reach the low texels; wide ones clamp to the last
        for (int i = 0; i < LOADED; i++)
            issue(write_word(i, 16'($urandom), 16'($urandom), 16'($urandom)));
        issue(write_word(0, 16'hffff, 16'hffff, 16'hffff));
        issue(write_word(C_TEXEL_COUNT - 1, 16'h0000, 16'h0000, 16'h0000));

        issue(sample_word(0, 0, 0));
        issue(sample_word(32767, 100, -200));
        issue(sample_word(-32768, 5, 7));
        issue(sample_word(3, 32767, -32768));
        issue(sample_word(-9, -32768, 32767));
        issue(sample_word(1, 2, 32767));
        issue(sample_word(-32768, -32768, -32768));
        issue(sample_word(32767, 32767, 0));
        issue(sample_word(0, 1000, 1000));
        issue(sample_word(-1000, 1000, -1000));
        issue(sample_word(32767, -32768, 32767));
        issue(sample_word(1, 0, 0));
        issue(sample_word(0, -1, 0));
        issue(sample_word(0, 0, -1));
        issue(sample_word(-32768, 32767, 32767));
        drain();

        for (int p = 0; p < 7; p++) begin
            if (p == 6) set_dims(14'($urandom_range(1, 16)), 14'($urandom_range(6, 16)));
            else set_dims(dims[p][0], dims[p][1]);
            idle_pct = (p < 3) ? 24 : (p < 5) ? 80 : 0;
            n = 145;
            for (int i = 0; i < n; i++)
                issue((p == 3 || p == 4) ? wide_word() : rand_word());
            drain();
        end

        drain();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+rtl
rtl/cbs_pkg.sv
rtl/cbs_div.sv
rtl/cbs_addr.sv
rtl/cbs_mem.sv
rtl/cbs_blend.sv
rtl/cubemap_bilinear_texture_sampler_core.sv
tb/cbs_checker.sv
tb/tb_top.sv
